// ----- design/nd_boundary_weight_scaler_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the N-dimensional boundary weight scaler
// ----------------------------------------------------------------------------
`ifndef ND_BOUNDARY_WEIGHT_SCALER_UNIT_MACROS_SVH
`define ND_BOUNDARY_WEIGHT_SCALER_UNIT_MACROS_SVH

// Checked on every rising edge once reset has been released.
`define NBWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nbws assertion failed");

// Checked on every rising edge, reset included.
`define NBWS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("nbws assertion failed during reset");

`endif

// ----- design/nbws_pkg.sv -----
// ----------------------------------------------------------------------------
// nbws_pkg
// Shared types and constants of the N-dimensional boundary weight scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nbws_pkg;

  localparam int MaxDims = 4;
  localparam int MaxSize = 4096;
  localparam int IdxW    = $clog2(MaxSize);
  localparam int ValW    = 32;
  localparam int CntW    = 3;
  localparam int DimsW   = 3;
  localparam int SizeW   = 13;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int RegIdxW = 3;

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  // Register indexes
  localparam logic [RegIdxW-1:0] RegNumDims  = 3'd0;
  localparam logic [RegIdxW-1:0] RegSizeDim0 = 3'd1;
  localparam logic [RegIdxW-1:0] RegSizeDim1 = 3'd2;
  localparam logic [RegIdxW-1:0] RegSizeDim2 = 3'd3;
  localparam logic [RegIdxW-1:0] RegSizeDim3 = 3'd4;

  localparam logic [DimsW-1:0] NumDimsReset = 3'd2;
  localparam logic [SizeW-1:0] SizeReset    = 13'd1;

  typedef struct packed {
    logic [DimsW-1:0]                num_dims;
    logic [MaxDims-1:0][SizeW-1:0]   size;
  } cfg_t;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [CntW-1:0]        count;
    logic                   last;
  } item_t;

endpackage

// ----- design/nbws_front.sv -----
// ----------------------------------------------------------------------------
// nbws_front
// Accepts elements, tracks the per-dimension indexes and classifies each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbws_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nbws_pkg::cfg_t                    cfg_i,
  input  logic                              push_i,
  input  logic signed [nbws_pkg::ValW-1:0]  value_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output nbws_pkg::item_t                   q_item_o
);

  logic [nbws_pkg::MaxDims-1:0][nbws_pkg::IdxW-1:0] idx_q, idx_d;
  logic [nbws_pkg::MaxDims-1:0][nbws_pkg::IdxW-1:0] last_w;
  logic [nbws_pkg::SizeW-1:0]                        size_m1;
  logic [nbws_pkg::DimsW-1:0]                        n_w;
  logic [nbws_pkg::CntW-1:0]                         count_w;
  logic                                              all_last_w;
  logic                                              carry_w;
  logic                                              at_last_w;
  logic                                              accept_w;

  assign accept_w = push_i && !q_full_i;

  // Clamp the dimension count and the sizes to their legal ranges
  always_comb begin
    if (cfg_i.num_dims == '0) begin
      n_w = nbws_pkg::DimsW'(1);
    end else if (cfg_i.num_dims > nbws_pkg::DimsW'(nbws_pkg::MaxDims)) begin
      n_w = nbws_pkg::DimsW'(nbws_pkg::MaxDims);
    end else begin
      n_w = cfg_i.num_dims;
    end
  end

  always_comb begin
    size_m1 = '0;
    for (int d = 0; d < nbws_pkg::MaxDims; d++) begin
      size_m1 = cfg_i.size[d] - nbws_pkg::SizeW'(1);
      if (cfg_i.size[d] == '0) begin
        last_w[d] = '0;
      end else if (cfg_i.size[d] > nbws_pkg::SizeW'(nbws_pkg::MaxSize)) begin
        last_w[d] = nbws_pkg::IdxW'(nbws_pkg::MaxSize - 1);
      end else begin
        last_w[d] = size_m1[nbws_pkg::IdxW-1:0];
      end
    end
  end

  // Count boundaries and advance the index odometer
  always_comb begin
    idx_d      = idx_q;
    count_w    = '0;
    all_last_w = 1'b1;
    carry_w    = 1'b1;
    at_last_w  = 1'b0;
    for (int d = 0; d < nbws_pkg::MaxDims; d++) begin
      if (nbws_pkg::DimsW'(d) >= n_w) begin
        idx_d[d] = '0;
      end else begin
        at_last_w = idx_q[d] >= last_w[d];
        if (idx_q[d] == '0 || at_last_w) begin
          count_w = count_w + nbws_pkg::CntW'(1);
        end
        if (!at_last_w) begin
          all_last_w = 1'b0;
        end
        if (carry_w) begin
          if (at_last_w) begin
            idx_d[d] = '0;
          end else begin
            idx_d[d] = idx_q[d] + nbws_pkg::IdxW'(1);
            carry_w  = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept_w) begin
      idx_q <= idx_d;
    end
  end

  assign q_push_o       = accept_w;
  assign q_item_o.value = value_i;
  assign q_item_o.count = count_w;
  assign q_item_o.last  = all_last_w;

endmodule

// ----- design/nbws_queue.sv -----
// ----------------------------------------------------------------------------
// nbws_queue
// Two-entry queue that decouples the classifier from the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbws_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nbws_pkg::item_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output nbws_pkg::item_t rdata_o
);

  nbws_pkg::item_t                mem_q [nbws_pkg::QDepth];
  logic [nbws_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [nbws_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = cnt_q == nbws_pkg::QCntW'(nbws_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + nbws_pkg::QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - nbws_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + nbws_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + nbws_pkg::QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- design/nbws_back.sv -----
// ----------------------------------------------------------------------------
// nbws_back
// Divides each element by its nonzero boundary count and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbws_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  nbws_pkg::item_t                   q_item_i,
  output logic                              q_pop_o,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic signed [nbws_pkg::ValW-1:0]  value_o,
  output logic [nbws_pkg::CntW-1:0]         count_o,
  output logic                              last_o
);

  localparam logic [nbws_pkg::ValW-1:0] Recip3 = 32'hAAAA_AAAB;

  // Stage 1: magnitude and sign
  logic                        s1_valid_q;
  logic [nbws_pkg::ValW-1:0]   s1_mag_q;
  logic                        s1_neg_q;
  logic [nbws_pkg::CntW-1:0]   s1_cnt_q;
  logic                        s1_last_q;

  // Stage 2: result register
  logic                              out_valid_q;
  logic signed [nbws_pkg::ValW-1:0]  out_value_q;
  logic [nbws_pkg::CntW-1:0]         out_cnt_q;
  logic                              out_last_q;

  logic                              out_free, s1_move, s1_load;
  logic [nbws_pkg::ValW-1:0]         in_neg;
  logic [2*nbws_pkg::ValW-1:0]       prod;
  logic [nbws_pkg::ValW-1:0]         quot;
  logic [nbws_pkg::ValW-1:0]         res;

  assign out_free = !out_valid_q || pop_i;
  assign s1_move  = s1_valid_q && out_free;
  assign s1_load  = !q_empty_i && (!s1_valid_q || s1_move);
  assign q_pop_o  = s1_load;
  assign in_neg   = -q_item_i.value;

  // Divide by one to four (a count of zero passes through): shifts, or reciprocal multiply for three
  always_comb begin
    prod = s1_mag_q * Recip3;
    case (s1_cnt_q)
      nbws_pkg::CntW'(2): quot = s1_mag_q >> 1;
      nbws_pkg::CntW'(3): quot = {1'b0, prod[2*nbws_pkg::ValW-1:nbws_pkg::ValW+1]};
      nbws_pkg::CntW'(4): quot = s1_mag_q >> 2;
      default:            quot = s1_mag_q;
    endcase
    res = s1_neg_q ? -quot : quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_mag_q  <= q_item_i.value[nbws_pkg::ValW-1] ? in_neg : q_item_i.value;
      s1_neg_q  <= q_item_i.value[nbws_pkg::ValW-1];
      s1_cnt_q  <= q_item_i.count;
      s1_last_q <= q_item_i.last;
    end
    if (s1_move) begin
      out_value_q <= res;
      out_cnt_q   <= s1_cnt_q;
      out_last_q  <= s1_last_q;
    end
  end

  assign empty_o = !out_valid_q;
  assign value_o = out_value_q;
  assign count_o = out_cnt_q;
  assign last_o  = out_last_q;

endmodule

// ----- design/nd_boundary_weight_scaler_unit.sv -----
// ----------------------------------------------------------------------------
// nd_boundary_weight_scaler_unit
// Streams an N-dimensional array and scales each element by its boundary count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive element_value_i with push high; a transfer happens
//   at a rising edge with push high and full low. Elements arrive in
//   row-major order, dimension 0 fastest.
//   Result channel: while empty is low the oldest result sits on
//   scaled_value_o, boundary_count_o and array_end_o; pop high at a rising
//   edge completes the transfer. array_end_o marks the last element.
//   Configuration: APB writes at 4*i set num_dims and the four sizes; write
//   only while no element is in flight. pready is tied high.
//   Path: queue, stage-1 register, result register. Throughput: one element
//   per cycle while full is low, set by the front classifier and the two-stage
//   divide pipeline, which both take one element per cycle when not stalled.
//   Reset: index counters clear, the queue and result register empty,
//   num_dims returns to 2 and all sizes to 1.
//   Stall: when pop stays low the result holds; the pipeline and the
//   two-entry queue fill, and full rises after four elements are waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nd_boundary_weight_scaler_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel
  input  logic                               push,
  output logic                               full,
  input  logic signed [nbws_pkg::ValW-1:0]   element_value_i,
  // Result channel
  output logic                               empty,
  input  logic                               pop,
  output logic signed [nbws_pkg::ValW-1:0]   scaled_value_o,
  output logic [nbws_pkg::CntW-1:0]          boundary_count_o,
  output logic                               array_end_o,
  // Configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nbws_pkg::AddrW-1:0]         paddr,
  input  logic [nbws_pkg::DataW-1:0]         pwdata,
  output logic [nbws_pkg::DataW-1:0]         prdata,
  output logic                               pready
);

  nbws_pkg::cfg_t                  cfg_q;
  logic                            cfg_wr;
  logic [nbws_pkg::RegIdxW-1:0]    reg_idx;

  logic                            q_push, q_full, q_pop, q_empty;
  nbws_pkg::item_t                 q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[nbws_pkg::AddrW-1:2];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_dims <= nbws_pkg::NumDimsReset;
      for (int d = 0; d < nbws_pkg::MaxDims; d++) begin
        cfg_q.size[d] <= nbws_pkg::SizeReset;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        nbws_pkg::RegNumDims:  cfg_q.num_dims <= pwdata[nbws_pkg::DimsW-1:0];
        nbws_pkg::RegSizeDim0: cfg_q.size[0]  <= pwdata[nbws_pkg::SizeW-1:0];
        nbws_pkg::RegSizeDim1: cfg_q.size[1]  <= pwdata[nbws_pkg::SizeW-1:0];
        nbws_pkg::RegSizeDim2: cfg_q.size[2]  <= pwdata[nbws_pkg::SizeW-1:0];
        nbws_pkg::RegSizeDim3: cfg_q.size[3]  <= pwdata[nbws_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      nbws_pkg::RegNumDims:  prdata = nbws_pkg::DataW'(cfg_q.num_dims);
      nbws_pkg::RegSizeDim0: prdata = nbws_pkg::DataW'(cfg_q.size[0]);
      nbws_pkg::RegSizeDim1: prdata = nbws_pkg::DataW'(cfg_q.size[1]);
      nbws_pkg::RegSizeDim2: prdata = nbws_pkg::DataW'(cfg_q.size[2]);
      nbws_pkg::RegSizeDim3: prdata = nbws_pkg::DataW'(cfg_q.size[3]);
      default:               prdata = '0;
    endcase
  end

  // Front: index tracking and boundary classification
  nbws_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push_i   (push),
    .value_i  (element_value_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_wdata)
  );

  assign full = q_full;

  // Queue between front and back
  nbws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  // Back: divide and hold the result for the receiver
  nbws_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_item_i  (q_rdata),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .value_o   (scaled_value_o),
    .count_o   (boundary_count_o),
    .last_o    (array_end_o)
  );

endmodule

// ----- design/nbws_checker.sv -----
// ----------------------------------------------------------------------------
// nbws_checker
// Port-level checks of the boundary weight scaler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nd_boundary_weight_scaler_unit_macros.svh"

module nbws_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input logic signed [nbws_pkg::ValW-1:0]   scaled_value_o,
  input logic [nbws_pkg::CntW-1:0]          boundary_count_o,
  input logic                               array_end_o
);

  // Count never exceeds the maximum number of dimensions
  `NBWS_ASSERT(a_count_range, !empty |-> boundary_count_o <= nbws_pkg::CntW'(nbws_pkg::MaxDims))

  // The final element, on the last index of every used dimension, has a nonzero count
  `NBWS_ASSERT(a_end_has_count, (!empty && array_end_o) |-> boundary_count_o != '0)

  // A stalled result holds
  `NBWS_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(scaled_value_o)))

  // Once reset has been applied, nothing waits and nothing blocks
  `NBWS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (empty && !full))

endmodule

bind nd_boundary_weight_scaler_unit nbws_checker u_nbws_checker (.*);
